// ===== hw/rtl/oad_pkg.sv =====
// ---------------------------------------------------------------------------
// Obstacle avoidance drive package
// Shared types, register codes and constants of the drive controller.
// ---------------------------------------------------------------------------
`default_nettype none

package oad_pkg;

  localparam int unsigned DistW  = 9;
  localparam int unsigned TimeW  = 16;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned CfgAw  = 5;
  localparam int unsigned CfgDw  = 32;

  localparam logic [SpeedW-1:0] SteerFast = 8'd135;
  localparam logic [SpeedW-1:0] SteerSlow = 8'd80;
  localparam logic [SpeedW-1:0] DutyMax   = 8'd255;

  localparam logic [DistW-1:0]  RstFrontStop = 9'd22;
  localparam logic [DistW-1:0]  RstSideStop  = 9'd14;
  localparam logic [TimeW-1:0]  RstBackupMs  = 16'd420;
  localparam logic [TimeW-1:0]  RstTurnMs    = 16'd520;
  localparam logic [SpeedW-1:0] RstFwdSpeed  = 8'd135;
  localparam logic [SpeedW-1:0] RstRevSpeed  = 8'd120;
  localparam logic [SpeedW-1:0] RstTurnSpeed = 8'd130;
  localparam logic [SpeedW-1:0] RstMinDuty   = 8'd70;

  typedef enum logic [1:0] {
    PH_CRUISE = 2'd0,
    PH_BACKUP = 2'd1,
    PH_TURN_L = 2'd2,
    PH_TURN_R = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DIR_COAST = 2'd0,
    DIR_FWD   = 2'd1,
    DIR_REV   = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    REG_FRONT_STOP = 3'd0,
    REG_SIDE_STOP  = 3'd1,
    REG_BACKUP_MS  = 3'd2,
    REG_TURN_MS    = 3'd3,
    REG_FWD_SPEED  = 3'd4,
    REG_REV_SPEED  = 3'd5,
    REG_TURN_SPEED = 3'd6,
    REG_MIN_DUTY   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [DistW-1:0]  front_stop;
    logic [DistW-1:0]  side_stop;
    logic [TimeW-1:0]  backup_ms;
    logic [TimeW-1:0]  turn_ms;
    logic [SpeedW-1:0] fwd_speed;
    logic [SpeedW-1:0] rev_speed;
    logic [SpeedW-1:0] turn_speed;
    logic [SpeedW-1:0] min_duty;
  } cfg_t;

  typedef struct packed {
    logic              neg;
    logic [SpeedW-1:0] mag;
  } motor_cmd_t;

  typedef struct packed {
    motor_cmd_t left;
    motor_cmd_t right;
  } drive_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/oad_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// Obstacle avoidance configuration registers
// APB register file holding thresholds, durations and speeds.
// ---------------------------------------------------------------------------
`default_nettype none

module oad_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [oad_pkg::CfgAw-1:0]   paddr,
  input  wire logic [oad_pkg::CfgDw-1:0]   pwdata,
  output logic      [oad_pkg::CfgDw-1:0]   prdata,
  output logic                             pready,
  output oad_pkg::cfg_t                    cfg_o
);
  import oad_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAw-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.front_stop <= RstFrontStop;
      cfg_q.side_stop  <= RstSideStop;
      cfg_q.backup_ms  <= RstBackupMs;
      cfg_q.turn_ms    <= RstTurnMs;
      cfg_q.fwd_speed  <= RstFwdSpeed;
      cfg_q.rev_speed  <= RstRevSpeed;
      cfg_q.turn_speed <= RstTurnSpeed;
      cfg_q.min_duty   <= RstMinDuty;
    end else if (wr_en) begin
      case (idx)
        REG_FRONT_STOP: cfg_q.front_stop <= pwdata[DistW-1:0];
        REG_SIDE_STOP:  cfg_q.side_stop  <= pwdata[DistW-1:0];
        REG_BACKUP_MS:  cfg_q.backup_ms  <= pwdata[TimeW-1:0];
        REG_TURN_MS:    cfg_q.turn_ms    <= pwdata[TimeW-1:0];
        REG_FWD_SPEED:  cfg_q.fwd_speed  <= pwdata[SpeedW-1:0];
        REG_REV_SPEED:  cfg_q.rev_speed  <= pwdata[SpeedW-1:0];
        REG_TURN_SPEED: cfg_q.turn_speed <= pwdata[SpeedW-1:0];
        REG_MIN_DUTY:   cfg_q.min_duty   <= pwdata[SpeedW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_FRONT_STOP: prdata = {{(CfgDw-DistW){1'b0}}, cfg_q.front_stop};
      REG_SIDE_STOP:  prdata = {{(CfgDw-DistW){1'b0}}, cfg_q.side_stop};
      REG_BACKUP_MS:  prdata = {{(CfgDw-TimeW){1'b0}}, cfg_q.backup_ms};
      REG_TURN_MS:    prdata = {{(CfgDw-TimeW){1'b0}}, cfg_q.turn_ms};
      REG_FWD_SPEED:  prdata = {{(CfgDw-SpeedW){1'b0}}, cfg_q.fwd_speed};
      REG_REV_SPEED:  prdata = {{(CfgDw-SpeedW){1'b0}}, cfg_q.rev_speed};
      REG_TURN_SPEED: prdata = {{(CfgDw-SpeedW){1'b0}}, cfg_q.turn_speed};
      REG_MIN_DUTY:   prdata = {{(CfgDw-SpeedW){1'b0}}, cfg_q.min_duty};
      default:        prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oad_drive_step.sv =====
// ---------------------------------------------------------------------------
// Obstacle avoidance phase step
// Next phase, countdown, signed motor commands and beep request for one tick.
// ---------------------------------------------------------------------------
`default_nettype none

module oad_drive_step (
  input  wire oad_pkg::cfg_t               cfg_i,
  input  wire oad_pkg::phase_e             phase_i,
  input  wire logic [oad_pkg::TimeW-1:0]   time_left_i,
  input  wire logic [oad_pkg::DistW-1:0]   dist_front_i,
  input  wire logic [oad_pkg::DistW-1:0]   dist_left_i,
  input  wire logic [oad_pkg::DistW-1:0]   dist_right_i,
  input  wire logic                        estop_i,
  output oad_pkg::phase_e                  phase_o,
  output logic      [oad_pkg::TimeW-1:0]   time_left_o,
  output oad_pkg::drive_cmd_t              cmd_o,
  output logic                             beep_o
);
  import oad_pkg::*;

  logic [TimeW-1:0] tl_dec;
  logic             expired;
  logic             left_blk;
  logic             right_blk;

  assign tl_dec    = (time_left_i != '0) ? time_left_i - TimeW'(1) : time_left_i;
  assign expired   = (tl_dec == '0);
  assign left_blk  = (dist_left_i <= cfg_i.side_stop);
  assign right_blk = (dist_right_i <= cfg_i.side_stop);

  always_comb begin
    phase_o     = phase_i;
    time_left_o = tl_dec;
    cmd_o       = '0;
    beep_o      = 1'b0;
    if (!estop_i) begin
      case (phase_i)
        PH_BACKUP: begin
          cmd_o.left.neg  = 1'b1;
          cmd_o.right.neg = 1'b1;
          cmd_o.left.mag  = cfg_i.rev_speed;
          cmd_o.right.mag = cfg_i.rev_speed;
          if (expired) begin
            phase_o     = (dist_left_i >= dist_right_i) ? PH_TURN_L : PH_TURN_R;
            time_left_o = cfg_i.turn_ms;
          end
        end
        PH_TURN_L: begin
          cmd_o.left.neg  = 1'b1;
          cmd_o.left.mag  = cfg_i.turn_speed;
          cmd_o.right.mag = cfg_i.turn_speed;
          if (expired) begin
            phase_o = PH_CRUISE;
          end
        end
        PH_TURN_R: begin
          cmd_o.right.neg = 1'b1;
          cmd_o.left.mag  = cfg_i.turn_speed;
          cmd_o.right.mag = cfg_i.turn_speed;
          if (expired) begin
            phase_o = PH_CRUISE;
          end
        end
        default: begin
          if (dist_front_i <= cfg_i.front_stop) begin
            beep_o          = 1'b1;
            phase_o         = PH_BACKUP;
            time_left_o     = cfg_i.backup_ms;
            cmd_o.left.neg  = 1'b1;
            cmd_o.right.neg = 1'b1;
            cmd_o.left.mag  = cfg_i.rev_speed;
            cmd_o.right.mag = cfg_i.rev_speed;
          end else if (left_blk && !right_blk) begin
            cmd_o.left.mag  = SteerFast;
            cmd_o.right.mag = SteerSlow;
          end else if (right_blk && !left_blk) begin
            cmd_o.left.mag  = SteerSlow;
            cmd_o.right.mag = SteerFast;
          end else begin
            cmd_o.left.mag  = cfg_i.fwd_speed;
            cmd_o.right.mag = cfg_i.fwd_speed;
          end
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/oad_duty_map.sv =====
// ---------------------------------------------------------------------------
// Obstacle avoidance duty mapping
// Turns a signed motor command into a direction and a compensated duty.
// ---------------------------------------------------------------------------
`default_nettype none

module oad_duty_map (
  input  wire oad_pkg::motor_cmd_t          cmd_i,
  input  wire logic [oad_pkg::SpeedW-1:0]   min_duty_i,
  output oad_pkg::dir_e                     dir_o,
  output logic      [oad_pkg::SpeedW-1:0]   duty_o
);
  import oad_pkg::*;

  logic [SpeedW-1:0]   mag_m1;
  logic [SpeedW-1:0]   span;
  logic [2*SpeedW-1:0] prod;
  logic [2*SpeedW-2:0] half;
  logic [SpeedW-1:0]   hi;
  logic [6:0]          lo;
  logic [SpeedW:0]     fold;
  logic [SpeedW-1:0]   quot;

  // The product divided by 254 is its half divided by 127. Since
  // 128 = 127 + 1, half = hi*127 + (hi + lo), and hi + lo stays below 381.
  assign mag_m1 = cmd_i.mag - SpeedW'(1);
  assign span   = DutyMax - min_duty_i;
  assign prod   = mag_m1 * span;
  assign half   = prod[2*SpeedW-1:1];
  assign hi     = half[2*SpeedW-2:7];
  assign lo     = half[6:0];
  assign fold   = {1'b0, hi} + {2'b00, lo};

  always_comb begin
    if (fold >= 9'd254) begin
      quot = hi + SpeedW'(2);
    end else if (fold >= 9'd127) begin
      quot = hi + SpeedW'(1);
    end else begin
      quot = hi;
    end
  end

  always_comb begin
    if (cmd_i.mag == '0) begin
      dir_o  = DIR_COAST;
      duty_o = '0;
    end else begin
      dir_o  = cmd_i.neg ? DIR_REV : DIR_FWD;
      duty_o = quot + min_duty_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/obstacle_avoid_drive_fsm_unit.sv =====
// ---------------------------------------------------------------------------
// Obstacle avoidance drive controller
// One tick per transaction: avoidance phase, countdown and motor outputs.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake               Contents
//  s_axis    in         tvalid/tready           distances, emergency stop
//  m_axis    out        tvalid/tready           motor dirs/duties, phase, beep
//  apb       in         psel/penable/pready     eight configuration registers
//
//  Each tick passes through the input register, then the result register.
//  A new tick is accepted every cycle unless the output stalls; the phase and
//  countdown registers are updated as a tick moves from input to result register.
//  A stalled output holds the result, and the input register keeps one more tick.
//  Reset returns the phase to cruise, the countdown to zero and loads defaults.
// ---------------------------------------------------------------------------
`default_nettype none

module obstacle_avoid_drive_fsm_unit (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // dist_front [8:0], dist_left [17:9], dist_right [26:18], zero fill
  input  wire logic [31:0]                 s_axis_tdata,
  // estop [0]
  input  wire logic                        s_axis_tuser,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // left_dir [1:0], left_duty [9:2], right_dir [11:10], right_duty [19:12],
  // phase [21:20], zero fill
  output logic      [23:0]                 m_axis_tdata,
  // beep_request [0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [oad_pkg::CfgAw-1:0]   paddr,
  input  wire logic [oad_pkg::CfgDw-1:0]   pwdata,
  output logic      [oad_pkg::CfgDw-1:0]   prdata,
  output logic                             pready
);
  import oad_pkg::*;

  cfg_t             cfg;
  logic             in_valid_q;
  logic [DistW-1:0] in_front_q;
  logic [DistW-1:0] in_left_q;
  logic [DistW-1:0] in_right_q;
  logic             in_estop_q;
  logic             advance;
  logic             in_take;
  phase_e           phase_q;
  phase_e           phase_d;
  logic [TimeW-1:0] time_left_q;
  logic [TimeW-1:0] time_left_d;
  drive_cmd_t       cmd;
  logic             beep;
  dir_e             left_dir;
  dir_e             right_dir;
  logic [7:0]       left_duty;
  logic [7:0]       right_duty;
  logic             out_valid_q;
  logic [23:0]      out_data_q;
  logic             out_beep_q;

  oad_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  oad_drive_step u_step (
    .cfg_i        (cfg),
    .phase_i      (phase_q),
    .time_left_i  (time_left_q),
    .dist_front_i (in_front_q),
    .dist_left_i  (in_left_q),
    .dist_right_i (in_right_q),
    .estop_i      (in_estop_q),
    .phase_o      (phase_d),
    .time_left_o  (time_left_d),
    .cmd_o        (cmd),
    .beep_o       (beep)
  );

  oad_duty_map u_duty_left (
    .cmd_i      (cmd.left),
    .min_duty_i (cfg.min_duty),
    .dir_o      (left_dir),
    .duty_o     (left_duty)
  );

  oad_duty_map u_duty_right (
    .cmd_i      (cmd.right),
    .min_duty_i (cfg.min_duty),
    .dir_o      (right_dir),
    .duty_o     (right_duty)
  );

  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_CRUISE;
      time_left_q <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        time_left_q <= time_left_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_front_q <= s_axis_tdata[8:0];
      in_left_q  <= s_axis_tdata[17:9];
      in_right_q <= s_axis_tdata[26:18];
      in_estop_q <= s_axis_tuser;
    end
    if (advance) begin
      out_data_q <= {2'b00, phase_d, right_duty, right_dir, left_duty, left_dir};
      out_beep_q <= beep;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_beep_q;

  a_beep_in_backup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[21:20] == PH_BACKUP)
    else $error("beep request without backup phase");

  a_estop_holds_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_estop_q |=> phase_q == $past(phase_q))
    else $error("phase changed during emergency stop");

  a_dir_code_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3 && m_axis_tdata[11:10] != 2'd3)
    else $error("illegal motor direction code");

  a_estop_coasts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_estop_q |=> m_axis_tdata[19:0] == 20'd0 && !m_axis_tuser)
    else $error("motors driven during emergency stop");

endmodule

`default_nettype wire
